// ===== rtl/mtep_pkg.sv =====
// package for the midi track event parser: phase codes, result kinds, constants
// no dependencies
`default_nettype none
package mtep_pkg;
    typedef enum logic [3:0] {
        PH_HEADER, PH_HDR_SKIP, PH_TRK_HDR, PH_DELTA, PH_STATUS, PH_META_TYPE,
        PH_META_LEN, PH_SYSEX_LEN, PH_TEMPO, PH_SKIP, PH_DATA1, PH_DATA2, PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        KIND_CHANNEL = 2'd0, KIND_TEMPO = 2'd1, KIND_OK = 2'd2, KIND_FAIL = 2'd3
    } kind_t;

    localparam int unsigned MAX_EVENTS = 1048576;
    localparam logic [15:0] DEFAULT_DIVISION = 16'd96;
    localparam logic [23:0] DEFAULT_TEMPO = 24'd500000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] tick;
        logic [7:0]  status;
        logic [7:0]  data1;
        logic [7:0]  data2;
        logic [23:0] tempo;
        logic [15:0] division;
        logic        last;
    } result_t;

    typedef struct packed {
        logic [7:0] file_byte;
        logic       final_byte;
    } item_t;
endpackage
`default_nettype wire

// ===== rtl/mtep_in_if.sv =====
// input channel interface: valid, ready and one file byte transaction
// depends on mtep_pkg
`default_nettype none
interface mtep_in_if;
    logic            valid;
    logic            ready;
    mtep_pkg::item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/mtep_out_if.sv =====
// output channel interface: valid, ready and one result transaction
// depends on mtep_pkg
`default_nettype none
interface mtep_out_if;
    logic              valid;
    logic              ready;
    mtep_pkg::result_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/mtep_out_queue.sv =====
// four-entry result queue between parse logic and the output channel
// depends on mtep_pkg and mtep_out_if
`default_nettype none
module mtep_out_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [1:0]        push_count,
    input  wire mtep_pkg::result_t push_a,
    input  wire mtep_pkg::result_t push_b,
    output logic [2:0]             fill,
    mtep_out_if.source             out_ch
);
    import mtep_pkg::*;

    result_t    slot_reg [4];
    logic [1:0] rd_reg;
    logic [1:0] wr_reg;
    logic [2:0] fill_reg;
    logic       pop;

    assign pop            = out_ch.valid && out_ch.ready;
    assign out_ch.valid   = fill_reg != 3'd0;
    assign out_ch.payload = slot_reg[rd_reg];
    assign fill           = fill_reg;

    // storage writes
    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            slot_reg[wr_reg] <= push_a;
        if (push_count == 2'd2)
            slot_reg[wr_reg + 2'd1] <= push_b;
    end

    // pointers and fill
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg   <= '0;
            wr_reg   <= '0;
            fill_reg <= '0;
        end
        else
        begin
            wr_reg   <= wr_reg + push_count;
            rd_reg   <= rd_reg + {1'b0, pop};
            fill_reg <= fill_reg + {1'b0, push_count} - {2'b0, pop};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= 3'd4)
        else $error("queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == 3'd0) |-> !out_ch.valid) else $error("valid while empty");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push_count == 2'd0 && !pop) |=> $stable(fill_reg)) else $error("fill drift");
endmodule
`default_nettype wire

// ===== rtl/midi_track_event_parser_core.sv =====
// top level of the midi track event parser: byte-wide parse state and result queue
// depends on mtep_pkg, mtep_in_if, mtep_out_if, mtep_out_queue

// Takes one standard MIDI file byte per cycle, back to back, and posts up to two
// results for it (an event and, on the final byte, the load summary) into a
// four-entry queue; a byte is taken whenever the queue, after this cycle's write
// and read, still has two free entries, so throughput is one byte per clock while
// the output side keeps up. Each byte is registered at the input and its results
// are written to the queue on the next cycle.
`default_nettype none
module midi_track_event_parser_core (
    input  wire logic clk,
    input  wire logic rst_n,
    mtep_in_if.sink   in_ch,
    mtep_out_if.source out_ch
);
    import mtep_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [31:0] offset_reg, offset_next;
    logic [31:0] hlen_reg, hlen_next;
    logic [31:0] trem_reg, trem_next;
    logic [31:0] rtick_reg, rtick_next;
    logic [7:0]  rstat_reg, rstat_next;
    logic        rvalid_reg, rvalid_next;
    logic [7:0]  cstat_reg, cstat_next;
    logic [7:0]  mtype_reg, mtype_next;
    logic [31:0] lacc_reg, lacc_next;
    logic [31:0] skip_reg, skip_next;
    logic [7:0]  fdata_reg, fdata_next;
    logic [23:0] tasm_reg, tasm_next;
    logic [20:0] evcnt_reg, evcnt_next;
    logic [31:0] ftick_reg, ftick_next;
    logic [23:0] itempo_reg, itempo_next;
    logic        scan_reg, scan_next;
    logic [15:0] tpq_reg, tpq_next;

    item_t       item_reg;
    logic        item_valid_reg;
    logic [2:0]  fill;
    logic [1:0]  push_count;
    result_t     push_a, push_b;
    logic        take;
    logic        pop;
    logic [3:0]  fill_after;

    // accept while the queue, after this cycle's write and read, has room for two
    assign pop         = out_ch.valid && out_ch.ready;
    assign fill_after  = {1'b0, fill} + {2'b0, push_count} - {3'b0, pop};
    assign in_ch.ready = fill_after <= 4'd2;
    assign take        = in_ch.valid && in_ch.ready;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            item_valid_reg <= 1'b0;
        else
            item_valid_reg <= take;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= in_ch.payload;
    end

    // parse step for the registered byte
    always_comb
    begin
        logic [7:0]  b;
        logic        ev;
        logic        is_tempo;
        logic [23:0] ev_tempo;
        logic [31:0] len;
        logic        data1_now;
        logic [15:0] tpq_w;
        result_t     ev_res;
        result_t     sum_res;

        b         = item_reg.file_byte;
        ev        = 1'b0;
        is_tempo  = 1'b0;
        ev_tempo  = '0;
        len       = '0;
        data1_now = 1'b0;
        tpq_w     = '0;
        ev_res    = '0;
        sum_res   = '0;

        phase_next  = phase_reg;
        offset_next = offset_reg;
        hlen_next   = hlen_reg;
        trem_next   = trem_reg;
        rtick_next  = rtick_reg;
        rstat_next  = rstat_reg;
        rvalid_next = rvalid_reg;
        cstat_next  = cstat_reg;
        mtype_next  = mtype_reg;
        lacc_next   = lacc_reg;
        skip_next   = skip_reg;
        fdata_next  = fdata_reg;
        tasm_next   = tasm_reg;
        evcnt_next  = evcnt_reg;
        ftick_next  = ftick_reg;
        itempo_next = itempo_reg;
        scan_next   = scan_reg;
        tpq_next    = tpq_reg;

        // division bytes at fixed offsets
        if (offset_reg == 32'd12)
            tpq_next = {b, 8'h00};
        if (offset_reg == 32'd13)
        begin
            tpq_w    = {tpq_reg[15:8], b};
            tpq_next = (tpq_w == 16'd0) ? DEFAULT_DIVISION : tpq_w;
        end

        unique case (phase_reg)
            PH_HEADER:
            begin
                if ((offset_reg == 32'd0 && b != 8'h4D) || (offset_reg == 32'd1 && b != 8'h54))
                    phase_next = PH_DONE;
                else if (offset_reg >= 32'd4 && offset_reg <= 32'd7)
                begin
                    hlen_next = {hlen_reg[23:0], b};
                    if (offset_reg == 32'd7)
                    begin
                        skip_next  = hlen_next;
                        phase_next = (hlen_next == 32'd0) ? PH_TRK_HDR : PH_HDR_SKIP;
                    end
                end
            end
            PH_HDR_SKIP:
            begin
                skip_next = skip_reg - 32'd1;
                if (skip_next == 32'd0)
                    phase_next = PH_TRK_HDR;
            end
            PH_TRK_HDR:
            begin
                if (skip_reg == 32'd0 && b != 8'h4D)
                    phase_next = PH_DONE;
                else
                begin
                    if (skip_reg >= 32'd4)
                        trem_next = {trem_reg[23:0], b};
                    skip_next = skip_reg + 32'd1;
                    if (skip_next == 32'd8)
                    begin
                        lacc_next  = '0;
                        phase_next = (trem_next == 32'd0) ? PH_DONE : PH_DELTA;
                    end
                end
            end
            PH_DELTA:
            begin
                if ({11'b0, evcnt_reg} >= MAX_EVENTS)
                    phase_next = PH_DONE;
                else
                begin
                    lacc_next = {lacc_reg[24:0], b[6:0]};
                    if (!b[7])
                    begin
                        rtick_next = rtick_reg + lacc_next;
                        lacc_next  = '0;
                        phase_next = PH_STATUS;
                    end
                end
            end
            PH_STATUS:
            begin
                if (!b[7])
                begin
                    if (!rvalid_reg)
                        phase_next = PH_DONE;
                    else
                    begin
                        cstat_next = rstat_reg;
                        data1_now  = 1'b1;
                    end
                end
                else
                begin
                    cstat_next = b;
                    if (b < 8'hF0)
                    begin
                        rstat_next  = b;
                        rvalid_next = 1'b1;
                    end
                    lacc_next = '0;
                    if (b == 8'hFF)
                        phase_next = PH_META_TYPE;
                    else if (b >= 8'hF0)
                        phase_next = PH_SYSEX_LEN;
                    else
                        phase_next = PH_DATA1;
                end
            end
            PH_DATA1:
                data1_now = 1'b1;
            PH_DATA2:
            begin
                ev         = 1'b1;
                ev_res     = '{KIND_CHANNEL, rtick_reg, cstat_reg, fdata_reg, b, 24'd0,
                               16'd0, 1'b0};
                phase_next = PH_DELTA;
            end
            PH_META_TYPE:
            begin
                mtype_next = b;
                lacc_next  = '0;
                phase_next = PH_META_LEN;
            end
            PH_META_LEN, PH_SYSEX_LEN:
            begin
                len       = (lacc_reg > 32'h01FF_FFFF) ? 32'hFFFF_FFFF
                                                       : {lacc_reg[24:0], b[6:0]};
                lacc_next = len;
                if (!b[7])
                begin
                    lacc_next = '0;
                    if (phase_reg == PH_META_LEN && mtype_reg == 8'h51 && len == 32'd3)
                    begin
                        tasm_next  = '0;
                        skip_next  = 32'd3;
                        phase_next = PH_TEMPO;
                    end
                    else if (len == 32'd0)
                        phase_next = PH_DELTA;
                    else
                    begin
                        skip_next  = len;
                        phase_next = PH_SKIP;
                    end
                end
            end
            PH_TEMPO:
            begin
                tasm_next = {tasm_reg[15:0], b};
                skip_next = skip_reg - 32'd1;
                if (skip_next == 32'd0)
                begin
                    ev         = 1'b1;
                    is_tempo   = 1'b1;
                    ev_tempo   = tasm_next;
                    ev_res     = '{KIND_TEMPO, rtick_reg, 8'd0, 8'd0, 8'd0, tasm_next,
                                   16'd0, 1'b0};
                    phase_next = PH_DELTA;
                end
            end
            PH_SKIP:
            begin
                skip_next = skip_reg - 32'd1;
                if (skip_next == 32'd0)
                    phase_next = PH_DELTA;
            end
            default:
                phase_next = PH_DONE;
        endcase

        // first data byte, direct or through running status
        if (data1_now)
        begin
            fdata_next = b;
            if (cstat_next[7:4] == 4'hC || cstat_next[7:4] == 4'hD)
            begin
                ev         = 1'b1;
                ev_res     = '{KIND_CHANNEL, rtick_next, cstat_next, b, 8'd0, 24'd0,
                               16'd0, 1'b0};
                phase_next = PH_DELTA;
            end
            else
                phase_next = PH_DATA2;
        end

        // event bookkeeping
        if (ev)
        begin
            if (evcnt_reg == 21'd0)
                ftick_next = rtick_next;
            evcnt_next = evcnt_reg + 21'd1;
            if (scan_reg)
            begin
                if (rtick_next != 32'd0)
                    scan_next = 1'b0;
                else if (is_tempo && ev_tempo != 24'd0)
                begin
                    itempo_next = ev_tempo;
                    scan_next   = 1'b0;
                end
            end
        end

        // track length bound
        if (phase_reg >= PH_DELTA && phase_reg < PH_DONE)
        begin
            trem_next = trem_reg - 32'd1;
            if (trem_next == 32'd0)
                phase_next = PH_DONE;
        end
        if (offset_reg != 32'hFFFF_FFFF)
            offset_next = offset_reg + 32'd1;

        // summary on the final byte
        if (evcnt_next != 21'd0)
            sum_res = '{KIND_OK, ftick_next, 8'd0, 8'd0, 8'd0, itempo_next, tpq_next, 1'b1};
        else
            sum_res = '{KIND_FAIL, 32'd0, 8'd0, 8'd0, 8'd0, 24'd0, 16'd0, 1'b1};

        push_count = 2'd0;
        push_a     = ev_res;
        push_b     = sum_res;
        if (item_valid_reg)
        begin
            if (item_reg.final_byte)
            begin
                push_count = ev ? 2'd2 : 2'd1;
                if (!ev)
                    push_a = sum_res;
            end
            else if (ev)
            begin
                push_count  = 2'd1;
                push_a.last = 1'b1;
            end
        end
    end

    // parse state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            offset_reg <= '0;
            hlen_reg   <= '0;
            trem_reg   <= '0;
            rtick_reg  <= '0;
            rstat_reg  <= '0;
            rvalid_reg <= 1'b0;
            cstat_reg  <= '0;
            mtype_reg  <= '0;
            lacc_reg   <= '0;
            skip_reg   <= '0;
            fdata_reg  <= '0;
            tasm_reg   <= '0;
            evcnt_reg  <= '0;
            ftick_reg  <= '0;
            itempo_reg <= DEFAULT_TEMPO;
            scan_reg   <= 1'b1;
            tpq_reg    <= DEFAULT_DIVISION;
        end
        else if (item_valid_reg && item_reg.final_byte)
        begin
            phase_reg  <= PH_HEADER;
            offset_reg <= '0;
            hlen_reg   <= '0;
            trem_reg   <= '0;
            rtick_reg  <= '0;
            rstat_reg  <= '0;
            rvalid_reg <= 1'b0;
            cstat_reg  <= '0;
            mtype_reg  <= '0;
            lacc_reg   <= '0;
            skip_reg   <= '0;
            fdata_reg  <= '0;
            tasm_reg   <= '0;
            evcnt_reg  <= '0;
            ftick_reg  <= '0;
            itempo_reg <= DEFAULT_TEMPO;
            scan_reg   <= 1'b1;
            tpq_reg    <= DEFAULT_DIVISION;
        end
        else if (item_valid_reg)
        begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
            hlen_reg   <= hlen_next;
            trem_reg   <= trem_next;
            rtick_reg  <= rtick_next;
            rstat_reg  <= rstat_next;
            rvalid_reg <= rvalid_next;
            cstat_reg  <= cstat_next;
            mtype_reg  <= mtype_next;
            lacc_reg   <= lacc_next;
            skip_reg   <= skip_next;
            fdata_reg  <= fdata_next;
            tasm_reg   <= tasm_next;
            evcnt_reg  <= evcnt_next;
            ftick_reg  <= ftick_next;
            itempo_reg <= itempo_next;
            scan_reg   <= scan_next;
            tpq_reg    <= tpq_next;
        end
    end

    mtep_out_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push_a     (push_a),
        .push_b     (push_b),
        .fill       (fill),
        .out_ch     (out_ch)
    );

    assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid_reg && item_reg.final_byte) |=> (phase_reg == PH_HEADER))
        else $error("no restart after final byte");
    assert property (@(posedge clk) disable iff (!rst_n)
        (push_count == 2'd2) |-> (item_valid_reg && item_reg.final_byte))
        else $error("double push without final byte");
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg |-> (fill <= 3'd2)) else $error("no room for results");
endmodule
`default_nettype wire
